// ===== rtl/core/amicable_number_check_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the amicable number check unit
// ---------------------------------------------------------------------------
`ifndef AMICABLE_NUMBER_CHECK_UNIT_ASSERT_SVH
`define AMICABLE_NUMBER_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amc assertion failed");

// Next-cycle implication, disabled during reset.
`define AMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amc assertion failed");

// Next-cycle implication that also covers reset cycles.
`define AMC_ASSERT_NEXT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("amc reset assertion failed");

`endif

// ===== rtl/core/amc_pkg.sv =====
// ---------------------------------------------------------------------------
// amc_pkg
// Shared constants and types of the amicable number check unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package amc_pkg;

  // Default width of the candidate number.
  localparam int NUM_WIDTH_DEF = 32;

  // Width of the aliquot sum and partner result fields.
  localparam int OUT_W = 35;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic done;      // one-cycle pulse, quotient and remainder valid
    logic rem_zero;  // remainder of the last division is zero
  } div_stat_t;

endpackage

// ===== rtl/core/amc_div.sv =====
// ---------------------------------------------------------------------------
// amc_div
// Restoring divider, one quotient bit per cycle, for the trial divisions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amc_div
  import amc_pkg::*;
#(
  parameter int SUM_W = 35,
  parameter int I_W   = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [I_W-1:0]   divisor,
  output logic [SUM_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r;
  logic [I_W-1:0]   rem_r;
  logic [I_W-1:0]   div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [I_W:0]     trial;
  logic             ge;
  logic [I_W:0]     diff;
  logic [I_W-1:0]   rem_nxt;
  logic [SUM_W-1:0] quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    ge      = (trial >= {1'b0, div_r});
    diff    = trial - {1'b0, div_r};
    rem_nxt = ge ? diff[I_W-1:0] : trial[I_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        div_r <= divisor;
        cnt_r <= CNT_W'(SUM_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient      = quo_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

// ===== rtl/core/amicable_number_check_unit.sv =====
// ---------------------------------------------------------------------------
// amicable_number_check_unit
// Tests one number for amicability through two aliquot sums by trial division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// request   in         start & !busy           in_number_in
// result    out        out_valid (1 cycle)     out_aliquot_sum, out_is_amicable,
//                                              out_partner
//
// Sequence: each pass over m tests divisors i = 1 .. floor(sqrt(m)), and each
// test runs a check, a divider load, SUM_W divide steps, a fold of i and a
// fold of m/i, with SUM_W = NUM_WIDTH + 3. Each pass closes with a failing
// check and an end-of-pass step; the first pass runs over m = n, the second
// over m = s(n), and the result strobe follows the end of the second pass.
// Reset: synchronous, active low; the unit comes out idle with no strobe.
// Stalls: busy is high from the accepted request until the result strobe;
// the receiver takes the result in the strobe cycle and cannot stall it.
// A new request may be accepted in the strobe cycle itself.

module amicable_number_check_unit
  import amc_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_number_in,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_aliquot_sum,
  output logic                 out_is_amicable,
  output logic [OUT_W-1:0]     out_partner
);

  // s(n) stays below 8n across the parameter range, sigma(s(n)) below 64n.
  localparam int SUM_W = NUM_WIDTH + 3;
  localparam int ACC_W = NUM_WIDTH + 6;
  // Trial divisor reaches floor(sqrt(m)) + 1, i*i one step past m.
  localparam int I_W   = (SUM_W + 1) / 2 + 1;
  localparam int SQ_W  = SUM_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACC_CO,
    ST_END_PASS
  } state_t;

  state_t             state_r;
  logic               pass_r;       // 0: sum over n, 1: sum over s(n)
  logic [NUM_WIDTH-1:0] n_r;
  logic [SUM_W-1:0]   m_r;          // number whose divisors are summed
  logic [SUM_W-1:0]   s1_r;
  logic [ACC_W-1:0]   total_r;      // running sum of all divisors of m
  logic [I_W-1:0]     i_r;          // trial divisor
  logic [SQ_W-1:0]    sq_r;         // i_r squared, kept by increments
  logic [SUM_W-1:0]   co_r;         // cofactor m / i
  logic               rz_r;         // i divides m
  logic               div_start_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   sum_out_r;
  logic               amic_r;

  logic [SUM_W-1:0]   quotient;
  div_stat_t          div_stat;

  logic [ACC_W-1:0]   s1_nxt;
  logic [ACC_W-1:0]   s2_nxt;
  logic               amic_nxt;
  logic [SQ_W-1:0]    sq_nxt;

  amc_div #(
    .SUM_W (SUM_W),
    .I_W   (I_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (m_r),
    .divisor  (i_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    // Aliquot sum is sigma(m) - m.
    s1_nxt   = total_r - ACC_W'(n_r);
    s2_nxt   = total_r - ACC_W'(s1_r);
    amic_nxt = (s2_nxt == ACC_W'(n_r)) && (s1_r != SUM_W'(n_r));
    // (i+1)^2 = i^2 + 2i + 1
    sq_nxt   = sq_r + SQ_W'({i_r, 1'b1});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            n_r     <= in_number_in;
            m_r     <= SUM_W'(in_number_in);
            total_r <= '0;
            i_r     <= I_W'(1);
            sq_r    <= SQ_W'(1);
            pass_r  <= 1'b0;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Loop runs while i*i <= m, i.e. i <= m / i.
          if (sq_r <= SQ_W'(m_r)) begin
            div_start_r <= 1'b1;
            state_r     <= ST_DIV;
          end else begin
            state_r <= ST_END_PASS;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            co_r <= quotient;
            rz_r <= div_stat.rem_zero;
            if (div_stat.rem_zero) begin
              total_r <= total_r + ACC_W'(i_r);
            end
            state_r <= ST_ACC_CO;
          end
        end
        ST_ACC_CO: begin
          // Cofactor counted once when i is the exact square root.
          if (rz_r && (co_r != SUM_W'(i_r))) begin
            total_r <= total_r + ACC_W'(co_r);
          end
          i_r     <= i_r + I_W'(1);
          sq_r    <= sq_nxt;
          state_r <= ST_CHECK;
        end
        ST_END_PASS: begin
          if (!pass_r) begin
            s1_r    <= s1_nxt[SUM_W-1:0];
            m_r     <= s1_nxt[SUM_W-1:0];
            total_r <= '0;
            i_r     <= I_W'(1);
            sq_r    <= SQ_W'(1);
            pass_r  <= 1'b1;
            state_r <= ST_CHECK;
          end else begin
            sum_out_r   <= OUT_W'(s1_r);
            amic_r      <= amic_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_aliquot_sum = sum_out_r;
  assign out_is_amicable = amic_r;
  assign out_partner     = amic_r ? sum_out_r : '0;

endmodule

// ===== rtl/core/amicable_number_check_unit_sva.sv =====
// ---------------------------------------------------------------------------
// amicable_number_check_unit_sva
// Port-level checks of the amicable number check unit, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "amicable_number_check_unit_assert.svh"

module amicable_number_check_unit_sva
  import amc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [OUT_W-1:0] out_aliquot_sum,
  input logic             out_is_amicable,
  input logic [OUT_W-1:0] out_partner
);

  logic [OUT_W-1:0] partner_want;

  assign partner_want = out_is_amicable ? out_aliquot_sum : '0;

  // Reset leaves the unit idle with no result strobe.
  `AMC_ASSERT_NEXT_RAW(a_reset_idle, clk, !rst_n, !busy && !out_valid)

  // An accepted request keeps the unit busy in the next cycle.
  `AMC_ASSERT_NEXT(a_req_busy, clk, rst_n, start && !busy, busy)

  // Every request passes through the check, divide and end-of-pass states, so strobes never come back to back.
  `AMC_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)

  // Partner is the aliquot sum for an amicable number and zero otherwise.
  `AMC_ASSERT_IMPL(a_partner, clk, rst_n, out_valid, out_partner == partner_want)

endmodule

bind amicable_number_check_unit amicable_number_check_unit_sva u_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_aliquot_sum (out_aliquot_sum),
  .out_is_amicable (out_is_amicable),
  .out_partner     (out_partner)
);

// ===== tb/amc_result_checker.sv =====
// ---------------------------------------------------------------------------
// amc_result_checker
// Predicts the verdict for each accepted request and checks the result strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amc_result_checker
  import amc_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_number_in,
  input  logic                 out_valid,
  input  logic [OUT_W-1:0]     out_aliquot_sum,
  input  logic                 out_is_amicable,
  input  logic [OUT_W-1:0]     out_partner,
  output int                   error_count,
  output int                   outstanding
);

  typedef struct packed {
    logic [NUM_WIDTH-1:0] number;
    logic [OUT_W-1:0]     sum;
    logic                 amicable;
    logic [OUT_W-1:0]     partner;
  } verdict_t;

  verdict_t pending_verdicts[$];
  int       mismatch_count = 0;
  int       queued = 0;

  assign error_count = mismatch_count;
  assign outstanding = queued;

  // Sum of divisors below m, by pairing i with m/i up to sqrt(m).
  function automatic logic [63:0] aliquot_sum_of(input logic [63:0] m);
    logic [63:0] total;
    logic [63:0] i;
    if (m < 64'd2) return 64'd0;
    total = 64'd0;
    for (i = 64'd1; i <= m / i; i++) begin
      if (m % i == 64'd0) begin
        total += i;
        if (m / i != i) total += m / i;
      end
    end
    return total - m;
  endfunction

  function automatic verdict_t judge_number(input logic [NUM_WIDTH-1:0] n);
    logic [63:0] wide_n;
    logic [63:0] s1;
    logic [63:0] s2;
    verdict_t    v;
    wide_n     = n;
    s1         = aliquot_sum_of(wide_n);
    s2         = aliquot_sum_of(s1);
    v.number   = n;
    v.sum      = s1[OUT_W-1:0];
    // perfect numbers map onto themselves and are excluded
    v.amicable = (s2 == wide_n) && (s1 != wide_n);
    v.partner  = v.amicable ? s1[OUT_W-1:0] : '0;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst_n) begin
      // result leaves before a request taken on the same edge is queued
      if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with no request pending (sum %0d)",
                                    out_aliquot_sum));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_aliquot_sum !== want.sum)
            report_mismatch($sformatf("n=%0d aliquot_sum %0d, want %0d",
                                      want.number, out_aliquot_sum, want.sum));
          if (out_is_amicable !== want.amicable)
            report_mismatch($sformatf("n=%0d is_amicable %0b, want %0b",
                                      want.number, out_is_amicable, want.amicable));
          if (out_partner !== want.partner)
            report_mismatch($sformatf("n=%0d partner %0d, want %0d",
                                      want.number, out_partner, want.partner));
        end
      end
      if (start && !busy) pending_verdicts.push_back(judge_number(in_number_in));
      queued <= pending_verdicts.size();
    end
  end

endmodule

// ===== tb/tb_amicable_number_check_unit.sv =====
// ---------------------------------------------------------------------------
// tb_amicable_number_check_unit
// Drives numbers into the amicable number check unit and reports the verdict.
// A directed list covers zero, one, the field maximum, squares, primes,
// perfect numbers and known amicable pairs; a random part follows, mostly
// small numbers and pair members, a few larger ones. The checker beside the
// unit predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_amicable_number_check_unit;
  import amc_pkg::*;

  localparam int NUM_W           = NUM_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 100;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [NUM_W-1:0] in_number_in = '0;
  logic             busy;
  logic             out_valid;
  logic [OUT_W-1:0] out_aliquot_sum;
  logic             out_is_amicable;
  logic [OUT_W-1:0] out_partner;
  int               error_count;
  int               outstanding;

  // Percent chance that the sender holds off before a request.
  int               idle_pct = 12;

  // Directed requests. Zero is outside the documented range but the unit
  // must still call it non-amicable with sum 0. 25 and 65536 are squares
  // (divisor paired with itself), 65537 is prime, all ones is the slowest
  // request of the run and sets every input bit.
  logic [NUM_W-1:0] directed_numbers [0:23] = '{
    0, 1, 2, 3, 4, 12, 25, 6, 28, 496, 8128,
    220, 284, 1184, 1210, 2620, 2924, 17296, 18416, 122368, 123152,
    65536, 65537, 32'hFFFF_FFFF
  };

  // Members of amicable pairs plus perfect numbers: the cases that get past
  // the first sum and exercise the second one and the guard.
  int unsigned known_numbers [0:29] = '{
    220, 284, 1184, 1210, 2620, 2924, 5020, 5564, 6232, 6368,
    10744, 10856, 12285, 14595, 17296, 18416, 63020, 76084, 66928, 66992,
    67095, 71145, 69615, 87633, 79750, 88730, 6, 28, 496, 8128
  };

  amicable_number_check_unit #(
    .NUM_WIDTH(NUM_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_number_in   (in_number_in),
    .out_valid      (out_valid),
    .out_aliquot_sum(out_aliquot_sum),
    .out_is_amicable(out_is_amicable),
    .out_partner    (out_partner)
  );

  amc_result_checker #(
    .NUM_WIDTH(NUM_W)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_number_in   (in_number_in),
    .out_valid      (out_valid),
    .out_aliquot_sum(out_aliquot_sum),
    .out_is_amicable(out_is_amicable),
    .out_partner    (out_partner),
    .error_count    (error_count),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Raise start with the number and hold both until the unit takes the
  // request. busy is read right after the edge, i.e. the value the unit saw.
  // start is left high so back-to-back requests need no extra edge.
  task automatic send_request(input logic [NUM_W-1:0] n);
    start        <= 1'b1;
    in_number_in <= n;
    do @(posedge clk); while (busy);
  endtask

  // Random hold-off: mostly short, sometimes long enough that the
  // unit finishes and sits idle before the next request shows up.
  task automatic maybe_idle();
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 2000);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back. The first
  // look is at the edge after start drops, so a request taken on this edge is
  // already counted.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int unsigned      pick;
    logic [NUM_W-1:0] n;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed list, light sender idling
    foreach (directed_numbers[k]) begin
      maybe_idle();
      send_request(directed_numbers[k]);
    end
    drain();

    // random part: light idling, then heavy, then back-to-back
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k == RANDOM_REQUESTS / 3) idle_pct = 83;
      else if (k == 2 * RANDOM_REQUESTS / 3) idle_pct = 0;

      // cost grows with sqrt(n), so keep most numbers small
      pick = $urandom_range(0, 99);
      if (pick < 35)      n = known_numbers[$urandom_range(0, 29)];
      else if (pick < 75) n = $urandom_range(1, 4095);
      else if (pick < 93) n = $urandom_range(4096, 65535);
      else if (pick < 99) n = $urandom_range(65536, 1 << 20);
      else                n = $urandom_range((1 << 20) + 1, 1 << 24);

      maybe_idle();
      send_request(n);
      if ($urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk);

    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports it as failing; the all-ones
  // request is the longest single request of the run.
  initial begin
    #1_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/amc_pkg.sv
rtl/core/amc_div.sv
rtl/core/amicable_number_check_unit.sv
rtl/core/amicable_number_check_unit_sva.sv
tb/amc_result_checker.sv
tb/tb_amicable_number_check_unit.sv
